/* sv/sliding_window_event_limiter_macros.svh */
// assertion macros shared by the checker
`ifndef SLIDING_WINDOW_EVENT_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_EVENT_LIMITER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SWEL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define SWEL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/swel_pkg.sv */
`timescale 1ns / 1ps

package swel_pkg;

    // fixed field widths of the stream and register interface
    localparam int TS_W   = 32;
    localparam int CNT_W  = 32;
    localparam int WIN_W  = 32;
    localparam int LIM_W  = 7;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [WIN_W-1:0] t_win;
    typedef logic [LIM_W-1:0] t_lim;
    typedef logic [0:0]       t_reg_idx;

    // register indexes
    localparam t_reg_idx REG_WINDOW = 1'b0;
    localparam t_reg_idx REG_LIMIT  = 1'b1;

    // register reset values
    localparam t_win WINDOW_RST = 32'd1;
    localparam t_lim LIMIT_RST  = 7'd2;

    // saturation value of the drop counter
    localparam t_cnt DROP_MAX = {CNT_W{1'b1}};

endpackage

/* sv/swel_ram.sv */
`timescale 1ns / 1ps

module swel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/sliding_window_event_limiter.sv */
`timescale 1ns / 1ps
// flow: an accepted event enters the check state, which retires expired entries
//   from the ring front one at a time, then registers the decision when the result
//   register is free; a new event is not taken until the current one is decided; only
//   the front timestamp is compared, read through the single ring ram read port
// reset: synchronous, active low; clears ring pointers, fill and drop count,
//   window_length to 1 and limit to 2; ring ram contents are not cleared
module sliding_window_event_limiter #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input events
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] timestamp
    input  logic [0:0]  s_axis_tuser,   // [0] start_new
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] dropped_count
    output logic [0:0]  m_axis_tuser,   // [0] admitted
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (TIME_BITS > swel_pkg::WIN_W) ? TIME_BITS : swel_pkg::WIN_W;
    localparam int NW = (FW > swel_pkg::LIM_W) ? FW : swel_pkg::LIM_W;
    localparam int SW = ((AW > FW) ? AW : FW) + 1;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    logic                  r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [FW-1:0]         r_fill, n_fill;
    swel_pkg::t_cnt        r_drop, n_drop;
    logic [TIME_BITS-1:0]  r_ts, n_ts;
    logic                  r_ovalid, n_ovalid;
    logic                  r_oadm, n_oadm;
    swel_pkg::t_cnt        r_ocnt, n_ocnt;
    swel_pkg::t_win        r_wlen;
    swel_pkg::t_lim        r_limit;

    logic                  in_acc;
    logic                  cfg_wr;
    logic [TIME_BITS-1:0]  front;
    logic [TIME_BITS-1:0]  age;
    logic                  expire;
    swel_pkg::t_lim        need;
    logic                  admit;
    logic [SW-1:0]         tail_sum;
    logic [AW-1:0]         tail;
    logic [AW-1:0]         head_inc;
    logic                  ram_we;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;

    // register read back
    always_comb begin
        case (paddr[2])
            swel_pkg::REG_WINDOW: prdata = r_wlen;
            swel_pkg::REG_LIMIT:  prdata = {{(32 - swel_pkg::LIM_W){1'b0}}, r_limit};
            default:              prdata = '0;
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= swel_pkg::WINDOW_RST;
            r_limit <= swel_pkg::LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                swel_pkg::REG_WINDOW: r_wlen  <= pwdata;
                swel_pkg::REG_LIMIT:  r_limit <= pwdata[swel_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // front entry age test
    assign age    = r_ts - front;
    assign expire = (r_fill != '0) && (r_ts >= front) &&
                    (CW'(age) >= CW'(r_wlen));

    // admit decision against limit-1 and ring capacity
    assign need  = (r_limit == '0) ? '0 : r_limit - 1'b1;
    assign admit = (NW'(r_fill) < NW'(need)) && (r_fill < FW'(QUEUE_DEPTH));

    // tail slot and head advance, wrapped at the ring depth
    assign tail_sum = SW'(r_head) + SW'(r_fill);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_fill   = r_fill;
        n_drop   = r_drop;
        n_ts     = r_ts;
        n_ovalid = r_ovalid;
        n_oadm   = r_oadm;
        n_ocnt   = r_ocnt;
        ram_we   = 1'b0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ts = TIME_BITS'(s_axis_tdata);
                    if (s_axis_tuser[0]) begin
                        n_head = '0;
                        n_fill = '0;
                        n_drop = '0;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (expire) begin
                    n_head = head_inc;
                    n_fill = r_fill - 1'b1;
                end else if (!r_ovalid || m_axis_tready) begin
                    if (admit) begin
                        ram_we = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end else if (r_drop != swel_pkg::DROP_MAX) begin
                        n_drop = r_drop + 1'b1;
                    end
                    n_ovalid = 1'b1;
                    n_oadm   = admit;
                    n_ocnt   = (admit || r_drop == swel_pkg::DROP_MAX) ?
                               r_drop : r_drop + 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_drop   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ts   <= n_ts;
        r_oadm <= n_oadm;
        r_ocnt <= n_ocnt;
    end

    // ring of admitted timestamps, read port follows the next head
    swel_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (r_ts),
        .i_raddr (n_head),
        .o_rdata (front)
    );

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_ocnt;
    assign m_axis_tuser[0] = r_oadm;

endmodule

/* sv/swel_checker.sv */
`timescale 1ns / 1ps
`include "sliding_window_event_limiter_macros.svh"

module swel_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        pready
);

    // a stalled result beat keeps its payload
    `SWEL_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result beat changed while stalled")

    // an accepted event makes the block busy and drops ready
    `SWEL_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "ready stayed high right after an input beat")

    // a dropped event always shows a nonzero drop count
    `SWEL_ASSERT_IMP(a_drop_counted, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata != 32'd0, "drop reported with zero drop count")

    // register port never inserts wait states
    `SWEL_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")

endmodule

bind sliding_window_event_limiter swel_checker u_swel_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int RING_DEPTH  = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int DIR_ROWS    = 30;

    typedef enum logic [1:0] {ROW_EVENT, ROW_BURST, ROW_WINDOW, ROW_LIMIT} t_row_kind;

    // one line of the directed table; typed rows carry their own verdict
    typedef struct packed {
        t_row_kind       kind;
        logic            start_new;
        logic [31:0]     value;
        int              reps;
        logic            typed;
        logic            admitted;
        swel_pkg::t_cnt  dropped_count;
    } t_row;

    typedef struct packed {
        logic            admitted;
        swel_pkg::t_cnt  dropped_count;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] timestamp
    logic [0:0]  s_axis_tuser;   // [0] start_new
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] dropped_count
    logic [0:0]  m_axis_tuser;   // [0] admitted
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the limiter state
    logic [31:0]     live_stamps[$];
    swel_pkg::t_cnt  drop_tally;
    swel_pkg::t_win  win_len;
    swel_pkg::t_lim  lim_val;

    t_verdict    pending_verdicts[$];
    t_row        dir_rows [0:DIR_ROWS-1];
    bit          quiet;
    int          errors;
    int          events_sent;
    int          admits_seen;
    int          drops_seen;
    int          settings_used;
    int          idle_cycles;

    sliding_window_event_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expire, decide, then store or count the drop
    function automatic void judge_event(input logic start_new, input logic [31:0] ts,
                                        output logic admit, output swel_pkg::t_cnt tally);
        int need;
        if (start_new) begin
            live_stamps.delete();
            drop_tally = '0;
        end
        while (live_stamps.size() > 0 && ts >= live_stamps[0] &&
               (ts - live_stamps[0]) >= win_len)
            void'(live_stamps.pop_front());
        need  = (lim_val == '0) ? 0 : int'(lim_val) - 1;
        admit = (live_stamps.size() < need) && (live_stamps.size() < RING_DEPTH);
        if (admit)
            live_stamps.push_back(ts);
        else if (drop_tally != swel_pkg::DROP_MAX)
            drop_tally = drop_tally + 1'b1;
        tally = drop_tally;
    endfunction

    // one event beat, with an optional gap in front of it
    task automatic drive_event(input logic start_new, input logic [31:0] ts,
                               input logic typed, input logic want_admit,
                               input swel_pkg::t_cnt want_tally);
        logic adm;
        swel_pkg::t_cnt tally;
        if (!quiet && $urandom_range(0, 99) < 31) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ts;
        s_axis_tuser  <= start_new;
        do @(posedge i_clk); while (!s_axis_tready);
        judge_event(start_new, ts, adm, tally);
        if (typed) begin
            adm   = want_admit;
            tally = want_tally;
        end
        pending_verdicts.push_back(t_verdict'{adm, tally});
        events_sent++;
        @(negedge i_clk);
    endtask

    // hold off input until every verdict is back and the block is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_read_check(input swel_pkg::t_reg_idx idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("prdata: expected %0h, actual %0h", want, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic reg_write_check(input swel_pkg::t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        if (idx == swel_pkg::REG_WINDOW) begin
            win_len = val;
            reg_read_check(swel_pkg::REG_WINDOW, val);
        end else begin
            lim_val = val[swel_pkg::LIM_W-1:0];
            reg_read_check(swel_pkg::REG_LIMIT, {25'd0, val[swel_pkg::LIM_W-1:0]});
        end
        settings_used++;
    endtask

    // result side: random backpressure, none while quiet
    always @(negedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 31);
    end

    // compare each result beat with the oldest verdict
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no event pending");
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tuser[0] !== want.admitted) begin
                    $error("admitted: expected %0d, actual %0d",
                           want.admitted, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata !== want.dropped_count) begin
                    $error("dropped_count: expected %0d, actual %0d",
                           want.dropped_count, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0])
                    admits_seen++;
                else
                    drops_seen++;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("sliding_window_event_limiter verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0]     cur_ts;
        logic [31:0]     ts;
        logic            start_new;
        longint unsigned span;
        int              pick;
        swel_pkg::t_win  ph_win;
        logic [31:0]     ph_lim;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        quiet         = 1'b0;
        errors        = 0;
        events_sent   = 0;
        admits_seen   = 0;
        drops_seen    = 0;
        settings_used = 0;
        idle_cycles   = 0;
        drop_tally    = '0;
        win_len       = swel_pkg::WINDOW_RST;
        lim_val       = swel_pkg::LIMIT_RST;

        // kind, start_new, value, reps, typed, admitted, dropped_count
        dir_rows = '{
            '{ROW_EVENT,  1'b0, 32'd0,          1,  1'b1, 1'b1, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd0,          1,  1'b1, 1'b0, 32'd1},
            '{ROW_EVENT,  1'b0, 32'd1,          1,  1'b1, 1'b1, 32'd1},
            '{ROW_EVENT,  1'b0, 32'hFFFF_FFFF,  1,  1'b1, 1'b1, 32'd1},
            // timestamp going backwards expires nothing
            '{ROW_EVENT,  1'b0, 32'd0,          1,  1'b1, 1'b0, 32'd2},
            '{ROW_EVENT,  1'b1, 32'hFFFF_FFFF,  1,  1'b1, 1'b1, 32'd0},
            // zero window: anything not later than now expires
            '{ROW_WINDOW, 1'b0, 32'd0,          1,  1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b0, 32'hFFFF_FFFF,  1,  1'b1, 1'b1, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd5,          1,  1'b1, 1'b0, 32'd1},
            // zero limit and limit one drop everything
            '{ROW_WINDOW, 1'b0, 32'hFFFF_FFFF,  1,  1'b0, 1'b0, 32'd0},
            '{ROW_LIMIT,  1'b0, 32'd0,          1,  1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b1, 32'd0,          1,  1'b1, 1'b0, 32'd1},
            '{ROW_EVENT,  1'b0, 32'd100,        1,  1'b1, 1'b0, 32'd2},
            '{ROW_LIMIT,  1'b0, 32'd1,          1,  1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b0, 32'h8000_0000,  1,  1'b1, 1'b0, 32'd3},
            '{ROW_LIMIT,  1'b0, 32'd4,          1,  1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b1, 32'd10,         1,  1'b1, 1'b1, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd10,         1,  1'b1, 1'b1, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd11,         1,  1'b1, 1'b1, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd12,         1,  1'b1, 1'b0, 32'd1},
            // limit lowered below the current fill
            '{ROW_LIMIT,  1'b0, 32'd2,          1,  1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd13,         1,  1'b1, 1'b0, 32'd2},
            // limit above ring depth: a full ring still drops
            '{ROW_LIMIT,  1'b0, 32'd127,        1,  1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b1, 32'd0,          1,  1'b1, 1'b1, 32'd0},
            '{ROW_BURST,  1'b0, 32'd0,          63, 1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd1,          1,  1'b1, 1'b0, 32'd1},
            // short window: one event flushes the whole ring
            '{ROW_WINDOW, 1'b0, 32'd1,          1,  1'b0, 1'b0, 32'd0},
            '{ROW_LIMIT,  1'b0, 32'd65,         1,  1'b0, 1'b0, 32'd0},
            '{ROW_EVENT,  1'b0, 32'd16,         1,  1'b1, 1'b1, 32'd1},
            '{ROW_EVENT,  1'b0, 32'd16,         1,  1'b0, 1'b0, 32'd0}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register values straight out of reset
        reg_read_check(swel_pkg::REG_WINDOW, swel_pkg::WINDOW_RST);
        reg_read_check(swel_pkg::REG_LIMIT, {25'd0, swel_pkg::LIMIT_RST});

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].kind)
                ROW_EVENT: begin
                    drive_event(dir_rows[r].start_new, dir_rows[r].value, dir_rows[r].typed,
                                dir_rows[r].admitted, dir_rows[r].dropped_count);
                end
                ROW_BURST: begin
                    repeat (dir_rows[r].reps)
                        drive_event(dir_rows[r].start_new, dir_rows[r].value,
                                    1'b0, 1'b0, '0);
                end
                ROW_WINDOW: begin
                    drain_results();
                    reg_write_check(swel_pkg::REG_WINDOW, dir_rows[r].value);
                end
                default: begin
                    drain_results();
                    reg_write_check(swel_pkg::REG_LIMIT, dir_rows[r].value);
                end
            endcase
        end

        // random phases, each under its own window and limit
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin ph_win = 32'd5;          ph_lim = 32'd3;   end
                1: begin ph_win = 32'd0;          ph_lim = 32'd2;   end
                2: begin ph_win = 32'hFFFF_FFFF;  ph_lim = 32'd127; end
                3: begin ph_win = 32'd1;          ph_lim = 32'd65;  end
                4: begin ph_win = 32'd20;         ph_lim = 32'd1;   end
                5: begin ph_win = $urandom_range(1, 200); ph_lim = $urandom_range(2, 10); end
                6: begin ph_win = $urandom_range(1, 5000); ph_lim = $urandom_range(20, 70); end
                default: begin ph_win = $urandom; ph_lim = $urandom_range(0, 127); end
            endcase
            reg_write_check(swel_pkg::REG_WINDOW, ph_win);
            reg_write_check(swel_pkg::REG_LIMIT, ph_lim);
            // one phase runs with no idling on either side
            quiet  = (ph == 3);
            cur_ts = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick      = $urandom_range(0, 99);
                start_new = (n == 0) || (pick < 4);
                if (start_new && pick < 2)
                    cur_ts = $urandom;
                span = (longint'(win_len) * 2) / ((lim_val < 2) ? 1 : longint'(lim_val) - 1) + 1;
                if (span > 64'hFFFF_FFFF)
                    span = 64'hFFFF_FFFF;
                if (pick >= 4 && pick < 12) begin
                    // out-of-order noise, leaves the running time alone
                    ts = $urandom;
                end else begin
                    ts     = cur_ts + $urandom_range(0, 32'(span));
                    cur_ts = ts;
                end
                drive_event(start_new, ts, 1'b0, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("%0d events sent across %0d register settings", events_sent, settings_used);
        $display("%0d admitted, %0d dropped, %0d mismatches", admits_seen, drops_seen, errors);
        if (errors == 0)
            $display("sliding_window_event_limiter verification clean");
        else
            $display("sliding_window_event_limiter verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/swel_pkg.sv
sv/swel_ram.sv
sv/sliding_window_event_limiter.sv
sv/swel_checker.sv
test/testbench.sv
